>>> src/bab_pkg.sv
// Shared constants, command codes and types of the block allocation bitmap.
package bab_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned POS_W          = 5;
    localparam int unsigned CNT_W          = 11;
    localparam int unsigned BLK_W          = 10;
    localparam int unsigned CMD_W          = 3;
    localparam int unsigned WIDX_W         = CNT_W - POS_W;
    localparam int unsigned MAX_BLOCKS_DEF = 1024;
    localparam int unsigned CNT_MAX        = (1 << CNT_W) - 1;

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(1024);

    localparam logic [CMD_W-1:0] CMD_FIND_FREE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK_FREE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COMPACT    = 3'd5;

    // Outcome of examining one bitmap word during a scan.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_eval;

endpackage

>>> src/bab_ifs.sv
// Valid/ready channel interfaces for commands and results.
interface bab_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [bab_pkg::CMD_W-1:0]        cmd;
    logic [bab_pkg::BLK_W-1:0]        block;
    logic [bab_pkg::CNT_W-1:0]        count;
    logic [bab_pkg::CNT_W-1:0]        free_space;

    modport source (output valid, cmd, block, count, free_space, input ready);
    modport sink   (input valid, cmd, block, count, free_space, output ready);
endinterface

interface bab_res_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [bab_pkg::BLK_W-1:0]        free_index;
    logic                             range_free;

    modport source (output valid, found, free_index, range_free, input ready);
    modport sink   (input valid, found, free_index, range_free, output ready);
endinterface

>>> src/bab_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bab_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bab_word_eval.sv
// Examines one bitmap word against a bit range: first free bit or any used bit.
module bab_word_eval (
    input  logic [bab_pkg::WORD_W-1:0] i_word,
    input  logic [bab_pkg::WIDX_W-1:0] i_widx,
    input  logic [bab_pkg::CNT_W-1:0]  i_lo,
    input  logic [bab_pkg::CNT_W-1:0]  i_hi,
    input  logic                       i_is_find,
    output bab_pkg::t_eval             o_eval
);

    logic [bab_pkg::WORD_W-1:0] m_lo;
    logic [bab_pkg::WORD_W-1:0] m_hi;
    logic [bab_pkg::WORD_W-1:0] cand;
    logic [bab_pkg::POS_W-1:0]  pos;

    always_comb begin
        // Only the first and last words of the range are partly covered.
        m_lo = {bab_pkg::WORD_W{1'b1}};
        m_hi = {bab_pkg::WORD_W{1'b1}};
        if (i_widx == i_lo[bab_pkg::CNT_W-1:bab_pkg::POS_W]) begin
            m_lo = {bab_pkg::WORD_W{1'b1}} << i_lo[bab_pkg::POS_W-1:0];
        end
        if (i_widx == i_hi[bab_pkg::CNT_W-1:bab_pkg::POS_W]) begin
            m_hi = {bab_pkg::WORD_W{1'b1}} >>
                   (bab_pkg::POS_W'(bab_pkg::WORD_W - 1) - i_hi[bab_pkg::POS_W-1:0]);
        end
        cand = i_is_find ? (~i_word & m_lo & m_hi) : (i_word & m_lo & m_hi);

        pos = '0;
        for (int i = bab_pkg::WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pos = bab_pkg::POS_W'(i);
            end
        end
        o_eval.hit = |cand;
        o_eval.pos = pos;
    end

endmodule

>>> src/block_allocation_bitmap_top.sv
// Top level of the block allocation bitmap: command decode, word scanner and fill sequencer.
//
// The used/free map lives in one RAM of 32-bit words with a registered read; each
// word has a valid flag in flip-flops, and a word that is not valid reads as all
// free, so reset and clear_all take effect at once with no clearing pass. One
// command is in flight at a time. find_free and check_free read one word per
// cycle. set and clear read, modify and write one word, and compact writes the
// used prefix word by word. A result waits in an output register, and the next
// command is taken from the cycle after the previous result has moved into it.
module block_allocation_bitmap_top #(
    parameter int unsigned MAX_BLOCKS = bab_pkg::MAX_BLOCKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bab_pkg::CNT_W-1:0] i_cfg_wdata,
    bab_cmd_if.sink                   i_cmd,
    bab_res_if.source                 o_res
);

    // Only blocks below the largest 11-bit count can ever be reached.
    localparam int unsigned CAP       = (MAX_BLOCKS > bab_pkg::CNT_MAX) ?
                                        bab_pkg::CNT_MAX : MAX_BLOCKS;
    localparam int unsigned NUM_WORDS = (CAP + bab_pkg::WORD_W - 1) / bab_pkg::WORD_W;
    localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [bab_pkg::CNT_W-1:0] CAP_C = bab_pkg::CNT_W'(CAP);

    localparam int unsigned W  = bab_pkg::WORD_W;
    localparam int unsigned CW = bab_pkg::CNT_W;
    localparam int unsigned PW = bab_pkg::POS_W;
    localparam int unsigned XW = bab_pkg::WIDX_W;
    localparam int unsigned BW = bab_pkg::BLK_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_RMW_RD = 6'b001000,
        S_RMW_WR = 6'b010000,
        S_FILL   = 6'b100000
    } t_state;

    // Finishing is shared by all commands: a separate flag moves the result out.
    t_state                        r_state, n_state;
    logic                          r_done, n_done;
    logic [CW-1:0]                 r_cfg;
    logic [NUM_WORDS-1:0]          r_wvld, n_wvld;
    logic [bab_pkg::CMD_W-1:0]     r_cmd;
    logic [BW-1:0]                 r_block;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_fs;
    logic [CW-1:0]                 r_lo, n_lo;
    logic [CW-1:0]                 r_hi, n_hi;
    logic                          r_is_find, n_is_find;
    logic [XW-1:0]                 r_rd_w, n_rd_w;
    logic                          r_iss_more, n_iss_more;
    logic                          r_pend, n_pend;
    logic [XW-1:0]                 r_pend_w, n_pend_w;
    logic                          r_rd_v, n_rd_v;
    logic [CW-1:0]                 r_len, n_len;
    logic [XW:0]                   r_fill_w, n_fill_w;
    logic [XW:0]                   r_fill_n, n_fill_n;
    logic                          r_found, n_found;
    logic [BW-1:0]                 r_fidx, n_fidx;
    logic                          r_rfree, n_rfree;
    logic                          r_out_vld, n_out_vld;
    logic                          r_o_found;
    logic [BW-1:0]                 r_o_fidx;
    logic                          r_o_rfree;

    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [W-1:0]                  ram_wdata, ram_rdata;
    logic [W-1:0]                  rd_word;
    logic [CW-1:0]                 bc;
    logic [CW:0]                   chk_end;
    logic signed [CW+1:0]          cmp_n;
    logic [XW-1:0]                 blk_w;
    logic [CW-1:0]                 pend_idx;
    logic                          load_out;
    bab_pkg::t_eval                ev;

    assign bc       = (r_cfg > CAP_C) ? CAP_C : r_cfg;
    assign chk_end  = {1'b0, CW'(r_block)} + {1'b0, r_count};
    assign cmp_n    = $signed({2'b00, bc}) - $signed({2'b00, r_fs})
                    + $signed({2'b00, r_count});
    assign blk_w    = XW'(r_block[BW-1:PW]);
    assign rd_word  = r_rd_v ? ram_rdata : '0;
    assign pend_idx = {r_pend_w, ev.pos};
    assign load_out = r_done && (!r_out_vld || o_res.ready);

    bab_ram #(
        .WIDTH (W),
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bab_word_eval u_eval (
        .i_word    (rd_word),
        .i_widx    (r_pend_w),
        .i_lo      (r_lo),
        .i_hi      (r_hi),
        .i_is_find (r_is_find),
        .o_eval    (ev)
    );

    assign i_cmd.ready = (r_state == S_IDLE) && !r_done;

    always_comb begin
        n_state    = r_state;
        n_done     = r_done;
        n_wvld     = r_wvld;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_is_find  = r_is_find;
        n_rd_w     = r_rd_w;
        n_iss_more = r_iss_more;
        n_pend     = r_pend;
        n_pend_w   = r_pend_w;
        n_rd_v     = r_rd_v;
        n_len      = r_len;
        n_fill_w   = r_fill_w;
        n_fill_n   = r_fill_n;
        n_found    = r_found;
        n_fidx     = r_fidx;
        n_rfree    = r_rfree;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = '0;
        ram_raddr  = '0;
        ram_wdata  = '0;

        if (load_out) begin
            n_done = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_found    = 1'b0;
                n_fidx     = '0;
                n_rfree    = 1'b0;
                n_iss_more = 1'b0;
                n_pend     = 1'b0;
                n_state    = S_IDLE;
                n_done     = 1'b1;
                unique case (r_cmd)
                    bab_pkg::CMD_FIND_FREE: begin
                        if (bc != '0) begin
                            n_lo       = '0;
                            n_hi       = bc - CW'(1);
                            n_rd_w     = '0;
                            n_iss_more = 1'b1;
                            n_is_find  = 1'b1;
                            n_state    = S_SCAN;
                            n_done     = 1'b0;
                        end
                    end
                    bab_pkg::CMD_SET, bab_pkg::CMD_CLEAR: begin
                        if (CW'(r_block) < bc) begin
                            n_state = S_RMW_RD;
                            n_done  = 1'b0;
                        end
                    end
                    bab_pkg::CMD_CHECK_FREE: begin
                        if (chk_end < {1'b0, bc}) begin
                            if (r_count == '0) begin
                                n_rfree = 1'b1;
                            end else begin
                                n_lo       = CW'(r_block) + CW'(1);
                                n_hi       = chk_end[CW-1:0];
                                n_rd_w     = n_lo[CW-1:PW];
                                n_iss_more = 1'b1;
                                n_is_find  = 1'b0;
                                n_state    = S_SCAN;
                                n_done     = 1'b0;
                            end
                        end
                    end
                    bab_pkg::CMD_CLEAR_ALL: begin
                        n_wvld = '0;
                    end
                    bab_pkg::CMD_COMPACT: begin
                        n_wvld = '0;
                        if (cmp_n < 0) begin
                            n_len = '0;
                        end else if (cmp_n > $signed({2'b00, bc})) begin
                            n_len = bc;
                        end else begin
                            n_len = cmp_n[CW-1:0];
                        end
                        n_fill_w = '0;
                        n_fill_n = (XW + 1)'(({1'b0, n_len} + (CW + 1)'(W - 1)) >> PW);
                        n_state  = S_FILL;
                        n_done   = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // One word is requested per cycle while the previous one is examined.
                ram_re     = r_iss_more;
                ram_raddr  = r_rd_w[AW-1:0];
                n_rd_w     = r_rd_w + XW'(1);
                n_iss_more = r_iss_more && (r_rd_w != r_hi[CW-1:PW]);
                n_pend     = r_iss_more;
                n_pend_w   = r_rd_w;
                n_rd_v     = r_wvld[r_rd_w[AW-1:0]];
                if (r_pend) begin
                    if (ev.hit) begin
                        n_found    = r_is_find;
                        n_fidx     = r_is_find ? pend_idx[BW-1:0] : '0;
                        n_rfree    = 1'b0;
                        n_iss_more = 1'b0;
                        n_pend     = 1'b0;
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                    end else if (r_pend_w == r_hi[CW-1:PW]) begin
                        n_rfree    = !r_is_find;
                        n_iss_more = 1'b0;
                        n_pend     = 1'b0;
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                    end
                end
            end
            S_RMW_RD: begin
                ram_re    = 1'b1;
                ram_raddr = blk_w[AW-1:0];
                n_rd_v    = r_wvld[blk_w[AW-1:0]];
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                ram_we    = 1'b1;
                ram_waddr = blk_w[AW-1:0];
                ram_wdata = rd_word;
                ram_wdata[r_block[PW-1:0]] = (r_cmd == bab_pkg::CMD_SET);
                n_wvld[blk_w[AW-1:0]] = 1'b1;
                n_state   = S_IDLE;
                n_done    = 1'b1;
            end
            S_FILL: begin
                if (r_fill_w < r_fill_n) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_fill_w[AW-1:0];
                    // Words below the end of the prefix are full; a word that holds its end is partial.
                    if (r_fill_w[XW-1:0] == r_len[CW-1:PW]) begin
                        ram_wdata = ~({W{1'b1}} << r_len[PW-1:0]);
                    end else begin
                        ram_wdata = {W{1'b1}};
                    end
                    n_wvld[r_fill_w[AW-1:0]] = 1'b1;
                    n_fill_w = r_fill_w + (XW + 1)'(1);
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_cfg      <= bab_pkg::CFG_RESET;
            r_wvld     <= '0;
            r_iss_more <= 1'b0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_wvld     <= n_wvld;
            r_iss_more <= n_iss_more;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd   <= i_cmd.cmd;
            r_block <= i_cmd.block;
            r_count <= i_cmd.count;
            r_fs    <= i_cmd.free_space;
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_is_find <= n_is_find;
        r_rd_w    <= n_rd_w;
        r_pend_w  <= n_pend_w;
        r_rd_v    <= n_rd_v;
        r_len     <= n_len;
        r_fill_w  <= n_fill_w;
        r_fill_n  <= n_fill_n;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_rfree   <= n_rfree;
        if (load_out) begin
            r_o_found <= r_found;
            r_o_fidx  <= r_fidx;
            r_o_rfree <= r_rfree;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.found      = r_o_found;
    assign o_res.free_index = r_o_fidx;
    assign o_res.range_free = r_o_rfree;

endmodule
